// ===== rtl/knnrp_pkg.sv =====
// ----------------------------------------------------------------------------
// knnrp_pkg
// Shared types and constants of the item-based KNN rating predictor.
// ----------------------------------------------------------------------------
package knnrp_pkg;

  // Item kinds
  localparam logic [1:0] KIND_BEGIN    = 2'd0;
  localparam logic [1:0] KIND_NEIGHBOR = 2'd1;
  localparam logic [1:0] KIND_FINISH   = 2'd2;

  // Configuration register indexes
  localparam logic [1:0] CFG_MIN_RATING = 2'd0;
  localparam logic [1:0] CFG_MAX_RATING = 2'd1;
  localparam int unsigned CFG_IDX_W = 2;

  localparam logic [15:0] MIN_RATING_RST = 16'd4096;
  localparam logic [15:0] MAX_RATING_RST = 16'd20480;

  // Accumulator and finish arithmetic widths
  localparam int unsigned NUM_W    = 48;
  localparam int unsigned DEN_W    = 32;
  localparam int unsigned PROD_W   = 33;
  localparam int unsigned ABS_W    = 17;
  localparam int unsigned DIVD_W   = NUM_W + 8;
  localparam int unsigned SUM_W    = DIVD_W + 2;
  localparam int unsigned STEP_W   = $clog2(DIVD_W);
  localparam int unsigned TOTAL_W  = 13;

  // 0.02 in Q1.15
  localparam logic [DEN_W-1:0] DEN_LIMIT = 32'd655;

  typedef struct packed {
    logic [1:0]         kind;
    logic signed [15:0] similarity;
    logic [3:0]         neighbor_rating;
    logic [15:0]        neighbor_mean;
    logic [15:0]        target_mean;
    logic signed [15:0] sim_threshold;
  } knnrp_in_t;

  typedef struct packed {
    logic [15:0]        prediction;
    logic               used_neighbors;
    logic [TOTAL_W-1:0] neighbor_total;
  } knnrp_out_t;

  typedef struct packed {
    logic [15:0] min_rating;
    logic [15:0] max_rating;
  } knnrp_cfg_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_ACC,
    ST_SQRT,
    ST_MUL,
    ST_DIV,
    ST_FIX,
    ST_EMIT
  } knnrp_state_t;

  // Controller to datapath
  typedef struct packed {
    logic begin_ld;
    logic nb_ld;
    logic acc_en;
    logic sqrt_ld;
    logic sqrt_step;
    logic mul_en;
    logic div_step;
    logic fix_en;
    logic emit_en;
  } knnrp_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic den_big;
  } knnrp_stat_t;

endpackage

// ===== rtl/knnrp_ctrl.sv =====
// ----------------------------------------------------------------------------
// knnrp_ctrl
// Sequencer: decodes accepted items and steps the finish computation.
// ----------------------------------------------------------------------------
module knnrp_ctrl import knnrp_pkg::*; #(
  parameter int unsigned MAX_NEIGHBORS = 4096
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  logic [1:0]  kind,
  input  knnrp_stat_t stat,
  output logic        busy,
  output knnrp_cmd_t  cmd
);

  localparam int unsigned CNT_W  = $clog2(MAX_NEIGHBORS + 1);
  localparam int unsigned ROOT_W = (CNT_W + 1) / 2 + 8;

  knnrp_state_t      state_r, state_nxt;
  logic [STEP_W-1:0] step_r, step_nxt;
  logic              accept;

  assign busy   = (state_r != ST_IDLE);
  assign accept = start && !busy;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      step_r  <= '0;
    end else begin
      state_r <= state_nxt;
      step_r  <= step_nxt;
    end
  end

  // Next state
  always_comb begin
    state_nxt = state_r;
    step_nxt  = step_r;
    unique case (state_r)
      ST_IDLE: begin
        if (accept) begin
          if (kind == KIND_NEIGHBOR) begin
            state_nxt = ST_ACC;
          end else if (kind == KIND_FINISH) begin
            state_nxt = stat.den_big ? ST_SQRT : ST_FIX;
            step_nxt  = STEP_W'(ROOT_W - 1);
          end
        end
      end
      ST_ACC:  state_nxt = ST_IDLE;
      ST_SQRT: begin
        if (step_r == '0) begin
          state_nxt = ST_MUL;
        end else begin
          step_nxt = step_r - 1'b1;
        end
      end
      ST_MUL: begin
        state_nxt = ST_DIV;
        step_nxt  = STEP_W'(DIVD_W - 1);
      end
      ST_DIV: begin
        if (step_r == '0) begin
          state_nxt = ST_FIX;
        end else begin
          step_nxt = step_r - 1'b1;
        end
      end
      ST_FIX:  state_nxt = ST_EMIT;
      ST_EMIT: state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  // Outputs
  always_comb begin
    cmd = '0;
    unique case (state_r)
      ST_IDLE: begin
        cmd.begin_ld = accept && (kind == KIND_BEGIN);
        cmd.nb_ld    = accept && (kind == KIND_NEIGHBOR);
        cmd.sqrt_ld  = accept && (kind == KIND_FINISH);
      end
      ST_ACC:  cmd.acc_en    = 1'b1;
      ST_SQRT: cmd.sqrt_step = 1'b1;
      ST_MUL:  cmd.mul_en    = 1'b1;
      ST_DIV:  cmd.div_step  = 1'b1;
      ST_FIX:  cmd.fix_en    = 1'b1;
      ST_EMIT: cmd.emit_en   = 1'b1;
      default: cmd = '0;
    endcase
  end

`ifndef SYNTHESIS
  a_nb_to_acc: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && kind == KIND_NEIGHBOR) |=> (state_r == ST_ACC))
    else $error("neighbor transfer did not enter accumulate");
  a_acc_single: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_ACC) |=> (state_r == ST_IDLE))
    else $error("accumulate lasted more than one cycle");
  a_div_end: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_DIV && step_r == '0) |=> (state_r == ST_FIX))
    else $error("divider did not hand over after last step");
  a_emit_idle: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.emit_en |=> (state_r == ST_IDLE && !cmd.emit_en))
    else $error("emit not followed by idle");
`endif

endmodule

// ===== rtl/knnrp_dpath.sv =====
// ----------------------------------------------------------------------------
// knnrp_dpath
// Accumulators, iterative square root, divisor multiply, restoring divider,
// final offset and clamp, result register.
// ----------------------------------------------------------------------------
module knnrp_dpath import knnrp_pkg::*; #(
  parameter int unsigned MAX_NEIGHBORS = 4096
) (
  input  logic        clk,
  input  logic        rst_n,
  input  knnrp_cmd_t  cmd,
  input  knnrp_in_t   in_data,
  input  knnrp_cfg_t  cfg,
  output knnrp_stat_t stat,
  output logic        out_valid,
  output knnrp_out_t  out_data
);

  localparam int unsigned CNT_W   = $clog2(MAX_NEIGHBORS + 1);
  localparam int unsigned ROOT_W  = (CNT_W + 1) / 2 + 8;
  localparam int unsigned SQ_W    = 2 * ROOT_W;
  localparam int unsigned REM_W   = ROOT_W + 2;
  localparam int unsigned DVSR_W  = DEN_W + ROOT_W;
  localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_NEIGHBORS);

  // Query state
  logic signed [NUM_W-1:0]  num_r;
  logic [DEN_W-1:0]         den_r;
  logic [CNT_W-1:0]         cnt_r;
  logic [15:0]              tm_r;
  logic signed [15:0]       thr_r;

  // Neighbor capture
  logic signed [PROD_W-1:0] prod_r, prod_nxt;
  logic [ABS_W-1:0]         abs_r, abs_nxt;
  logic                     sel_r;
  logic signed [16:0]       diff;
  logic signed [16:0]       sim_x;

  // Accumulate
  logic signed [NUM_W:0]    nsum;
  logic signed [NUM_W-1:0]  num_nxt;
  logic [DEN_W:0]           dsum;
  logic [DEN_W-1:0]         den_nxt;

  // Square root
  logic [SQ_W-1:0]          sq_src_r;
  logic [REM_W-1:0]         sq_rem_r;
  logic [ROOT_W-1:0]        root_r;
  logic [REM_W+1:0]         sq_sh;
  logic [REM_W+1:0]         sq_trial;
  logic [CNT_W-1:0]         cnt_eff;

  // Divide
  logic [DVSR_W-1:0]        dvsr_r;
  logic [DIVD_W-1:0]        dq_r;
  logic [DVSR_W-1:0]        drem_r;
  logic [DVSR_W:0]          drem_sh;
  logic                     neg_r;
  logic [NUM_W-1:0]         mag;

  // Finish
  logic [SUM_W-1:0]         sum_nxt;
  logic signed [SUM_W-1:0]  sum_r;
  logic                     used_r;
  logic signed [SUM_W-1:0]  min_x, max_x;
  logic signed [SUM_W-1:0]  lo_clamped, clamped;
  logic [CNT_W+TOTAL_W-1:0] cnt_wide;

  logic                     out_valid_r;
  knnrp_out_t               out_data_r;

  assign stat.den_big = (den_r > DEN_LIMIT);

  // rating in Q4.12 minus neighbor mean
  assign diff     = $signed({1'b0, in_data.neighbor_rating, 12'b0})
                  - $signed({1'b0, in_data.neighbor_mean});
  assign sim_x    = 17'(in_data.similarity);
  assign prod_nxt = in_data.similarity * diff;
  assign abs_nxt  = sim_x[16] ? ABS_W'(-sim_x) : ABS_W'(sim_x);

  assign nsum = (NUM_W+1)'(num_r) + (NUM_W+1)'(prod_r);
  always_comb begin
    if (nsum[NUM_W] != nsum[NUM_W-1]) begin
      num_nxt = nsum[NUM_W] ? {1'b1, {(NUM_W-1){1'b0}}} : {1'b0, {(NUM_W-1){1'b1}}};
    end else begin
      num_nxt = nsum[NUM_W-1:0];
    end
  end

  assign dsum    = (DEN_W+1)'(den_r) + (DEN_W+1)'(abs_r);
  assign den_nxt = dsum[DEN_W] ? {DEN_W{1'b1}} : dsum[DEN_W-1:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      num_r <= '0;
      den_r <= '0;
      cnt_r <= '0;
      tm_r  <= '0;
      thr_r <= '0;
    end else if (cmd.begin_ld) begin
      num_r <= '0;
      den_r <= '0;
      cnt_r <= '0;
      tm_r  <= in_data.target_mean;
      thr_r <= in_data.sim_threshold;
    end else if (cmd.nb_ld) begin
      if (cnt_r < CNT_MAX) begin
        cnt_r <= cnt_r + 1'b1;
      end
    end else if (cmd.acc_en && sel_r) begin
      num_r <= num_nxt;
      den_r <= den_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.nb_ld) begin
      prod_r <= prod_nxt;
      abs_r  <= abs_nxt;
      sel_r  <= (in_data.similarity >= thr_r);
    end
  end

  // Square root of count * 2^16, two radicand bits per step
  assign cnt_eff  = (cnt_r == '0) ? CNT_W'(1) : cnt_r;
  assign sq_sh    = {sq_rem_r, sq_src_r[SQ_W-1 -: 2]};
  assign sq_trial = (REM_W+2)'({root_r, 2'b01});

  always_ff @(posedge clk) begin
    if (cmd.sqrt_ld) begin
      sq_src_r <= SQ_W'({cnt_eff, 16'b0});
      sq_rem_r <= '0;
      root_r   <= '0;
    end else if (cmd.sqrt_step) begin
      sq_src_r <= {sq_src_r[SQ_W-3:0], 2'b00};
      if (sq_sh >= sq_trial) begin
        sq_rem_r <= REM_W'(sq_sh - sq_trial);
        root_r   <= {root_r[ROOT_W-2:0], 1'b1};
      end else begin
        sq_rem_r <= sq_sh[REM_W-1:0];
        root_r   <= {root_r[ROOT_W-2:0], 1'b0};
      end
    end
  end

  // Divisor multiply, then restoring division one quotient bit per step
  assign mag     = num_r[NUM_W-1] ? (~num_r + 1'b1) : num_r;
  assign drem_sh = {drem_r, dq_r[DIVD_W-1]};

  always_ff @(posedge clk) begin
    if (cmd.mul_en) begin
      dvsr_r <= DVSR_W'(den_r) * DVSR_W'(root_r);
      dq_r   <= {mag, 8'b0};
      drem_r <= '0;
      neg_r  <= num_r[NUM_W-1];
    end else if (cmd.div_step) begin
      if (drem_sh >= {1'b0, dvsr_r}) begin
        drem_r <= DVSR_W'(drem_sh - {1'b0, dvsr_r});
        dq_r   <= {dq_r[DIVD_W-2:0], 1'b1};
      end else begin
        drem_r <= drem_sh[DVSR_W-1:0];
        dq_r   <= {dq_r[DIVD_W-2:0], 1'b0};
      end
    end
  end

  // Offset target mean by the signed quotient, or pass it unchanged when den_big is low
  always_comb begin
    if (!stat.den_big) begin
      sum_nxt = SUM_W'(tm_r);
    end else if (neg_r) begin
      sum_nxt = SUM_W'(tm_r) - SUM_W'(dq_r);
    end else begin
      sum_nxt = SUM_W'(tm_r) + SUM_W'(dq_r);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.fix_en) begin
      sum_r  <= sum_nxt;
      used_r <= stat.den_big;
    end
  end

  // Raise to min, then lower to max: max wins when the limits cross
  assign min_x      = $signed(SUM_W'(cfg.min_rating));
  assign max_x      = $signed(SUM_W'(cfg.max_rating));
  assign lo_clamped = (sum_r < min_x) ? min_x : sum_r;
  assign clamped    = (lo_clamped > max_x) ? max_x : lo_clamped;
  assign cnt_wide   = (CNT_W+TOTAL_W)'(cnt_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= cmd.emit_en;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit_en) begin
      out_data_r.prediction     <= clamped[15:0];
      out_data_r.used_neighbors <= used_r;
      out_data_r.neighbor_total <= cnt_wide[TOTAL_W-1:0];
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

// ===== rtl/knn_rating_predictor_unit.sv =====
// ----------------------------------------------------------------------------
// knn_rating_predictor_unit
// Item-based KNN rating prediction with iterative finish arithmetic.
// ----------------------------------------------------------------------------
// Usage:
//   Input: drive in_data and raise start; the item transfers at a clock edge
//   where start is high and busy is low. A begin item loads the target mean
//   and similarity threshold and clears the sums (busy stays low). A neighbor
//   item first captures the product, then accumulates; busy is high during
//   the accumulate step. Kind code 3 is dropped.
//   Finish item: when the denominator is at most 0.02 the clamped target mean
//   appears on out_data after the fix and emit states. Otherwise the square
//   root unit forms a ROOT_W-bit root (15 bits at the default MAX_NEIGHBORS),
//   a multiply step forms the divisor, the restoring divider develops a
//   56-bit quotient one bit per cycle, then offset, clamp and the output
//   register give the result.
//   Output: out_valid is high for exactly one cycle with out_data; the
//   receiver must take it then. A new item may transfer in that cycle.
//   Configuration: cfg_ready is always high; index 0 writes min_rating,
//   index 1 max_rating, other indexes are dropped. Write only while idle.
//   Reset (rst_n low, synchronous): limits return to 1.0 and 5.0, sums,
//   count and held target values clear, the sequencer returns to idle.
// ----------------------------------------------------------------------------
module knn_rating_predictor_unit import knnrp_pkg::*; #(
  parameter int unsigned MAX_NEIGHBORS = 4096
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 start,
  output logic                 busy,
  input  knnrp_in_t            in_data,
  output logic                 out_valid,
  output knnrp_out_t           out_data,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [15:0]          cfg_data
);

  knnrp_cfg_t  cfg_r;
  knnrp_cmd_t  cmd;
  knnrp_stat_t stat;

  // Limit registers take a transfer every cycle
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.min_rating <= MIN_RATING_RST;
      cfg_r.max_rating <= MAX_RATING_RST;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_MIN_RATING: cfg_r.min_rating <= cfg_data;
        CFG_MAX_RATING: cfg_r.max_rating <= cfg_data;
        default: ;
      endcase
    end
  end

  // Sequencer: decode kind, count square root and divide steps
  knnrp_ctrl #(
    .MAX_NEIGHBORS (MAX_NEIGHBORS)
  ) u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .kind  (in_data.kind),
    .stat  (stat),
    .busy  (busy),
    .cmd   (cmd)
  );

  // Arithmetic and result register
  knnrp_dpath #(
    .MAX_NEIGHBORS (MAX_NEIGHBORS)
  ) u_dpath (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .in_data   (in_data),
    .cfg       (cfg_r),
    .stat      (stat),
    .out_valid (out_valid),
    .out_data  (out_data)
  );

endmodule
